FILE: design/ifba_pkg.sv
// Shared constants, types and state codes for the IMU FIFO burst averager.
package ifba_pkg;

   localparam int AXES                = 6;
   localparam int SAMPLE_W            = 16;
   localparam int HEADER_W            = 8;
   localparam int COUNT_OUT_W         = 6;
   localparam int DEFAULT_MAX_SAMPLES = 32;

   // sized for the largest burst length of 64 packets
   localparam int SUM_W  = 22;
   localparam int NUM_W  = 24;
   localparam int MAG_W  = 23;
   localparam int STEP_W = $clog2(MAG_W);

   localparam int REQ_DATA_W = HEADER_W + AXES * SAMPLE_W;
   localparam int RSP_FIELD_W = AXES * SAMPLE_W + COUNT_OUT_W;
   localparam int RSP_DATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_MUST_SET   = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_MUST_CLEAR = CSR_INDEX_W'(1);

   localparam logic [HEADER_W-1:0] MUST_SET_RESET   = 8'h60;
   localparam logic [HEADER_W-1:0] MUST_CLEAR_RESET = 8'h93;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [SUM_W-1:0]    sum_type;
   typedef logic signed [NUM_W-1:0]    num_type;

   typedef sample_type sample_vec_type [AXES];
   typedef sum_type    sum_vec_type    [AXES];
   typedef num_type    num_vec_type    [AXES];

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CLOSE,
      ST_DIV,
      ST_STORE
   } state_type;

endpackage

FILE: design/ifba_div_lanes.sv
// Six-lane bit-serial signed divider, one quotient bit per lane per cycle.
module ifba_div_lanes
   import ifba_pkg::*;
#(
   parameter int DEN_W = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  num_vec_type      num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output sample_vec_type   quot
);

   logic                 busy_ff;
   logic                 busy_in;
   logic                 done_ff;
   logic                 done_in;
   logic [STEP_W-1:0]    step_ff;
   logic [STEP_W-1:0]    step_in;
   logic [DEN_W-1:0]     den_ff;
   logic                 neg_ff  [AXES];
   logic [MAG_W-1:0]     mag_ff  [AXES];
   logic [MAG_W-1:0]     mag_in  [AXES];
   logic [DEN_W-1:0]     rem_ff  [AXES];
   logic [DEN_W-1:0]     rem_in  [AXES];

   always_comb begin
      logic [DEN_W:0] trial;
      trial   = '0;
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      for (int i = 0; i < AXES; i++) begin
         mag_in[i] = mag_ff[i];
         rem_in[i] = rem_ff[i];
      end
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         for (int i = 0; i < AXES; i++) begin
            mag_in[i] = num[i][NUM_W-1] ? MAG_W'(-num[i]) : MAG_W'(num[i]);
            rem_in[i] = '0;
         end
      end else if (busy_ff) begin
         for (int i = 0; i < AXES; i++) begin
            trial = {rem_ff[i], mag_ff[i][MAG_W-1]};
            if (trial >= {1'b0, den_ff}) begin
               rem_in[i] = DEN_W'(trial - {1'b0, den_ff});
               mag_in[i] = {mag_ff[i][MAG_W-2:0], 1'b1};
            end else begin
               rem_in[i] = trial[DEN_W-1:0];
               mag_in[i] = {mag_ff[i][MAG_W-2:0], 1'b0};
            end
         end
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(MAG_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         den_ff <= den;
         for (int i = 0; i < AXES; i++) begin
            neg_ff[i] <= num[i][NUM_W-1];
         end
      end
      for (int i = 0; i < AXES; i++) begin
         mag_ff[i] <= mag_in[i];
         rem_ff[i] <= rem_in[i];
      end
   end

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         quot[i] = neg_ff[i] ? SAMPLE_W'(-mag_ff[i]) : SAMPLE_W'(mag_ff[i]);
      end
   end

   assign done = done_ff;

endmodule

FILE: design/imu_fifo_burst_averager_core.sv
// A packet without tlast is absorbed while idle; a burst close runs through ST_CLOSE,
// ST_DIV and ST_STORE from the last item to the result register.
// Throughput: one item per cycle inside a burst; the bit-serial divider, one
// quotient bit per cycle for all six axes, sets the close time.
// Reset: synchronous, active high; clears sums, samples, reports, count, masks to
// their defaults, and empties the result register.
module imu_fifo_burst_averager_core
   import ifba_pkg::*;
#(
   parameter int MAX_SAMPLES = DEFAULT_MAX_SAMPLES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // header, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // avg_accel_x, avg_accel_y, avg_accel_z, avg_gyro_x, avg_gyro_y, avg_gyro_z,
   // valid_count, zero pad
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int DEN_W = CNT_W + 1;

   state_type             state_ff;
   state_type             state_in;
   logic [HEADER_W-1:0]   must_set_ff;
   logic [HEADER_W-1:0]   must_clear_ff;
   sum_vec_type           sums_ff;
   sample_vec_type        newest_ff;
   sample_vec_type        prev_ff;
   logic [CNT_W-1:0]      count_ff;
   logic                  stopped_ff;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;

   logic                  accept;
   logic                  header_ok;
   logic [HEADER_W-1:0]   header;
   logic                  div_start;
   logic                  div_done;
   logic                  store_fire;
   logic                  clear_burst;
   logic                  out_free;
   num_vec_type           div_num;
   sample_vec_type        div_quot;

   assign header    = req_tdata[HEADER_W-1:0];
   assign header_ok = ((header & must_set_ff) == must_set_ff) &&
                      ((header & must_clear_ff) == '0);
   assign accept    = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_tlast) begin
               state_in = ST_CLOSE;
            end
         end
         ST_CLOSE: begin
            state_in = (count_ff == '0) ? ST_IDLE : ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready  = 1'b0;
      div_start   = 1'b0;
      store_fire  = 1'b0;
      clear_burst = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_tready = 1'b1;
         ST_CLOSE: begin
            div_start   = (count_ff != '0);
            clear_burst = (count_ff == '0);
         end
         ST_DIV:   ;
         ST_STORE: begin
            store_fire  = out_free;
            clear_burst = out_free;
         end
         default:  ;
      endcase
   end

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         div_num[i] = NUM_W'(newest_ff[i]) + NUM_W'(prev_ff[i]) +
                      (NUM_W'(sums_ff[i]) <<< 1);
      end
   end

   ifba_div_lanes #(
      .DEN_W (DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   ({count_ff, 1'b0}),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         must_set_ff   <= MUST_SET_RESET;
         must_clear_ff <= MUST_CLEAR_RESET;
         count_ff      <= '0;
         stopped_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < AXES; i++) begin
            sums_ff[i]   <= '0;
            newest_ff[i] <= '0;
            prev_ff[i]   <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MUST_SET:   must_set_ff   <= csr_wdata;
               CSR_MUST_CLEAR: must_clear_ff <= csr_wdata;
               default:        ;
            endcase
         end
         if (accept && !stopped_ff) begin
            if (!header_ok) begin
               stopped_ff <= 1'b1;
            end else if (count_ff < CNT_W'(MAX_SAMPLES)) begin
               for (int i = 0; i < AXES; i++) begin
                  if (count_ff != '0) begin
                     sums_ff[i] <= sums_ff[i] + SUM_W'(newest_ff[i]);
                  end
                  newest_ff[i] <= req_tdata[HEADER_W + i*SAMPLE_W +: SAMPLE_W];
               end
               count_ff <= count_ff + CNT_W'(1);
            end
         end
         if (store_fire) begin
            for (int i = 0; i < AXES; i++) begin
               prev_ff[i] <= div_quot[i];
            end
         end
         if (clear_burst) begin
            count_ff   <= '0;
            stopped_ff <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
               sums_ff[i] <= '0;
            end
         end
         if (store_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      rsp_data_in = '0;
      for (int i = 0; i < AXES; i++) begin
         rsp_data_in[i*SAMPLE_W +: SAMPLE_W] = div_quot[i];
      end
      rsp_data_in[AXES*SAMPLE_W +: COUNT_OUT_W] = COUNT_OUT_W'(count_ff);
   end

   always_ff @(posedge clock) begin
      if (store_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
